// File: rtl/core/format_signature_checker_macros.svh
// Assertion macros for the port-level checks of the format signature checker.
`ifndef FORMAT_SIGNATURE_CHECKER_MACROS_SVH
`define FORMAT_SIGNATURE_CHECKER_MACROS_SVH

// Check that a condition in the same cycle implies another, outside reset.
`define FSC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fsc assertion failed");

// Check that a condition implies another in the next cycle, outside reset.
`define FSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fsc assertion failed");

// Check a consequence of reset itself, so no disable clause.
`define FSC_ASSERT_AFTER_RST(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("fsc assertion failed");

`endif

// File: rtl/core/fsc_pkg.sv
// Shared types and constants of the format signature checker.
package fsc_pkg;

  // Widest signature count any supported slot count needs.
  localparam int CNT_MAX_W   = 6;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = 2;

  typedef struct packed {
    logic       action;
    logic [7:0] text_byte;
  } in_item_t;

  typedef struct packed {
    logic       compatible;
    logic [3:0] key_sig_len;
    logic [3:0] repl_sig_len;
  } out_item_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_CLEAR,
    OP_WRITE,
    OP_CMP,
    OP_REPORT
  } op_t;

  typedef struct packed {
    op_t                  op;
    logic [7:0]           ch;
    logic [CNT_MAX_W-1:0] idx;
    logic                 over;
    logic                 eq;
    logic [3:0]           key_len;
    logic [3:0]           repl_len;
  } cmd_t;

endpackage

// File: rtl/core/fsc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module fsc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 15,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

// File: rtl/core/fsc_front.sv
// Front end: parses format bytes and issues signature commands.
module fsc_front #(
  parameter int SIG_SLOTS = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             take,
  input  fsc_pkg::in_item_t item,
  output logic             push,
  output fsc_pkg::cmd_t    cmd
);
  import fsc_pkg::*;

  localparam int CNT_W = $clog2(SIG_SLOTS);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(SIG_SLOTS - 1);

  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_PCT = 8'h25;

  typedef enum logic [1:0] {PH_TEXT, PH_PCT, PH_FLAGS, PH_MODS} phase_t;

  function automatic logic is_skip(input logic [7:0] c);
    return (c == 8'h2d) || (c == 8'h2b) || (c == 8'h20) || (c == 8'h23) ||
           (c == 8'h2e) || (c == 8'h2a) || ((c >= 8'h30) && (c <= 8'h39));
  endfunction

  function automatic logic is_mod(input logic [7:0] c);
    return (c == 8'h68) || (c == 8'h6c) || (c == 8'h4c) || (c == 8'h7a) ||
           (c == 8'h6a) || (c == 8'h74);
  endfunction

  phase_t           phase_r, phase_nxt, ph_in, ph_p;
  logic [CNT_W-1:0] key_cnt_r, key_cnt_nxt, kc_in;
  logic [CNT_W-1:0] repl_cnt_r, repl_cnt_nxt, rc_in;
  logic             closed_r, closed_nxt;
  logic             rec;
  logic             restart;

  // A key byte after a closed key restarts; a replacement byte closes an open key.
  always_comb begin
    restart = !item.action && closed_r;
    ph_in   = ((item.action && !closed_r) || restart) ? PH_TEXT : phase_r;
    kc_in   = restart ? '0 : key_cnt_r;
    rc_in   = restart ? '0 : repl_cnt_r;
  end

  always_comb begin
    rec  = 1'b0;
    ph_p = ph_in;
    unique case (ph_in) inside
      PH_TEXT: begin
        if (item.text_byte == CH_PCT) ph_p = PH_PCT;
      end
      PH_PCT, PH_FLAGS: begin
        if ((ph_in == PH_PCT) && (item.text_byte == CH_PCT)) begin
          ph_p = PH_TEXT;
        end else if (is_skip(item.text_byte)) begin
          ph_p = PH_FLAGS;
        end else if (is_mod(item.text_byte)) begin
          rec  = 1'b1;
          ph_p = PH_MODS;
        end else begin
          rec  = 1'b1;
          ph_p = PH_TEXT;
        end
      end
      PH_MODS: begin
        rec  = 1'b1;
        ph_p = is_mod(item.text_byte) ? PH_MODS : PH_TEXT;
      end
      default: ph_p = PH_TEXT;
    endcase
  end

  always_comb begin
    phase_nxt    = ph_p;
    key_cnt_nxt  = kc_in;
    repl_cnt_nxt = rc_in;
    closed_nxt   = 1'b1;
    cmd          = '0;
    cmd.op       = OP_NONE;
    cmd.ch       = item.text_byte;
    if (!item.action) begin
      closed_nxt = 1'b0;
      if (restart) cmd.op = OP_CLEAR;
      if (item.text_byte == CH_NUL) begin
        closed_nxt = 1'b1;
        phase_nxt  = PH_TEXT;
      end else if (rec && (kc_in < LAST)) begin
        cmd.op      = OP_WRITE;
        cmd.idx     = CNT_MAX_W'(kc_in);
        key_cnt_nxt = kc_in + CNT_W'(1);
      end
    end else if (item.text_byte != CH_NUL) begin
      if (rec && (rc_in < LAST)) begin
        cmd.op       = OP_CMP;
        cmd.idx      = CNT_MAX_W'(rc_in);
        cmd.over     = (rc_in >= kc_in);
        repl_cnt_nxt = rc_in + CNT_W'(1);
      end
    end else begin
      // Report, then return to the reset state for the next key.
      cmd.op       = OP_REPORT;
      cmd.eq       = (rc_in == kc_in);
      cmd.key_len  = 4'(kc_in);
      cmd.repl_len = 4'(rc_in);
      phase_nxt    = PH_TEXT;
      key_cnt_nxt  = '0;
      repl_cnt_nxt = '0;
      closed_nxt   = 1'b0;
    end
  end

  assign push = take && (cmd.op != OP_NONE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_TEXT;
      key_cnt_r  <= '0;
      repl_cnt_r <= '0;
      closed_r   <= 1'b0;
    end else if (take) begin
      phase_r    <= phase_nxt;
      key_cnt_r  <= key_cnt_nxt;
      repl_cnt_r <= repl_cnt_nxt;
      closed_r   <= closed_nxt;
    end
  end

endmodule

// File: rtl/core/fsc_queue.sv
// Short command queue between the parsing front end and the signature back end.
module fsc_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  fsc_pkg::cmd_t push_cmd,
  output logic          full,
  output logic          valid,
  output fsc_pkg::cmd_t cmd,
  input  logic          pop
);
  import fsc_pkg::*;

  cmd_t                entry_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QUEUE_AW:0]   cnt_r, cnt_nxt;

  assign full  = (cnt_r == (QUEUE_AW + 1)'(QUEUE_DEPTH));
  assign valid = (cnt_r != '0);
  assign cmd   = entry_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + (QUEUE_AW + 1)'(1);
    if (!push && pop) cnt_nxt = cnt_r - (QUEUE_AW + 1)'(1);
  end

  always_ff @(posedge clk) begin
    if (push) entry_r[wr_ptr_r] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + QUEUE_AW'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + QUEUE_AW'(1);
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// File: rtl/core/fsc_back.sv
// Back end: stores the key signature, compares the replacement, reports.
module fsc_back #(
  parameter int SIG_SLOTS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  fsc_pkg::cmd_t      q_cmd,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output fsc_pkg::out_item_t out_data
);
  import fsc_pkg::*;

  localparam int DEPTH = SIG_SLOTS - 1;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  cmd_t       s2_cmd_r;
  logic       s2_valid_r;
  logic       mismatch_r, mismatch_nxt;
  logic       out_valid_r;
  out_item_t  out_data_r;
  logic       out_free, s2_go;
  logic [7:0] rdata;

  assign out_free = !out_valid_r || !out_stall;
  // Only a report can hold the second stage: it waits for the output register.
  assign s2_go    = !s2_valid_r || (s2_cmd_r.op != OP_REPORT) || out_free;
  assign pop      = q_valid && s2_go;

  fsc_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_sig_ram (
    .clk   (clk),
    .we    (pop && (q_cmd.op == OP_WRITE)),
    .waddr (q_cmd.idx[AW-1:0]),
    .wdata (q_cmd.ch),
    .re    (pop && (q_cmd.op == OP_CMP) && !q_cmd.over),
    .raddr (q_cmd.idx[AW-1:0]),
    .rdata (rdata)
  );

  always_comb begin
    mismatch_nxt = mismatch_r;
    if (s2_valid_r && s2_go) begin
      unique case (s2_cmd_r.op) inside
        OP_CLEAR, OP_WRITE, OP_REPORT: mismatch_nxt = 1'b0;
        OP_CMP: begin
          if (s2_cmd_r.over || (rdata != s2_cmd_r.ch)) mismatch_nxt = 1'b1;
        end
        default: mismatch_nxt = mismatch_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (s2_go) s2_cmd_r <= q_cmd;
    if (out_free) begin
      out_data_r.compatible   <= !mismatch_r && s2_cmd_r.eq;
      out_data_r.key_sig_len  <= s2_cmd_r.key_len;
      out_data_r.repl_sig_len <= s2_cmd_r.repl_len;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r  <= 1'b0;
      mismatch_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s2_go) s2_valid_r <= pop;
      mismatch_r <= mismatch_nxt;
      if (out_free) out_valid_r <= s2_valid_r && (s2_cmd_r.op == OP_REPORT);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: rtl/core/format_signature_checker.sv
// Format signature checker top level: parser front end, command queue, compare back end.
// Throughput: one item per cycle; in_stall rises only while the four-entry command queue is full.
// Result path: a report passes the command queue, the second stage and the output register
//   before out_valid, and waits longer when earlier commands sit in the queue or the output is stalled.
// Reset: synchronous, active low; clears parse state, counts, queue and output valid.
// The signature RAM is not cleared; only entries written for the current key are read.
module format_signature_checker #(
  parameter int SIG_SLOTS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  fsc_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output fsc_pkg::out_item_t out_data
);
  import fsc_pkg::*;

  logic take;
  logic push;
  cmd_t push_cmd;
  logic q_full;
  logic q_valid;
  cmd_t q_cmd;
  logic pop;

  // Stall input only on a full queue; this never depends on out_stall directly.
  assign in_stall = q_full;
  assign take     = in_valid && !in_stall;

  // Front end: track the printf phase and the two signature counts, and turn
  // each item into at most one command (write key slot, compare, clear, report).
  fsc_front #(
    .SIG_SLOTS (SIG_SLOTS)
  ) u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .take  (take),
    .item  (in_data),
    .push  (push),
    .cmd   (push_cmd)
  );

  // Decouple the two halves so an output stall does not block parsing at once.
  fsc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .valid    (q_valid),
    .cmd      (q_cmd),
    .pop      (pop)
  );

  // Back end: write key characters, read and compare replacement characters one
  // stage later, and hold the result in the output register.
  fsc_back #(
    .SIG_SLOTS (SIG_SLOTS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// File: rtl/core/fsc_checker.sv
// Port-level checks of the format signature checker, bound to the top level.
`include "format_signature_checker_macros.svh"

module fsc_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input fsc_pkg::out_item_t out_data
);

  logic lens_eq;

  // A compatible report must carry equal signature lengths.
  assign lens_eq = (out_data.key_sig_len == out_data.repl_sig_len);

  `FSC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data))
  `FSC_ASSERT_NOW(a_compat_len, clk, rst_n, out_valid && out_data.compatible, lens_eq)
  `FSC_ASSERT_AFTER_RST(a_reset_idle, clk, !rst_n, !out_valid && !in_stall)

endmodule

bind format_signature_checker fsc_checker u_fsc_checker (.*);

// File: tb/format_signature_checker_tb.sv
// Testbench for the format signature checker: directed cases, random format string pairs and noise against a predictor.
`timescale 1ns / 100ps

module format_signature_checker_tb;
  import fsc_pkg::*;

  localparam int SIG_SLOTS    = 16;
  localparam int TARGET_ITEMS = 1600;
  localparam int HOLD_CYCLES  = 300;   // long receiver hold-off
  localparam int DRAIN_CYCLES = 16;    // settle time once nothing is pending

  localparam logic       ACT_KEY  = 1'b0;
  localparam logic       ACT_REPL = 1'b1;
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_PCT   = 8'h25;

  typedef enum logic [1:0] {
    PH_TEXT,
    PH_PCT,
    PH_FLAGS,
    PH_MODS
  } phase_e;

  // Scoreboard: tracks the parse of both strings and queues one expected report
  // for every replacement terminator.
  class sig_scoreboard;
    int         slots;
    phase_e     phase;
    logic [7:0] key_sig [64];
    int         key_cnt;
    int         repl_cnt;
    bit         mismatch;
    bit         key_closed;
    bit         in_repl;
    out_item_t  expected_q[$];
    int         errors;
    int         results_seen;
    int         compatible_seen;
    int         longest_key;

    function new(int n);
      slots = n;
      errors = 0;
      results_seen = 0;
      compatible_seen = 0;
      longest_key = 0;
      foreach (key_sig[i]) key_sig[i] = 8'h00;
      clear();
    endfunction

    static function bit is_skip(logic [7:0] c);
      return c == "-" || c == "+" || c == " " || c == "#" || c == "." || c == "*" ||
             (c >= "0" && c <= "9");
    endfunction

    static function bit is_mod(logic [7:0] c);
      return c == "h" || c == "l" || c == "L" || c == "z" || c == "j" || c == "t";
    endfunction

    function void clear();
      phase = PH_TEXT;
      key_cnt = 0;
      repl_cnt = 0;
      mismatch = 1'b0;
      key_closed = 1'b0;
      in_repl = 1'b0;
    endfunction

    // Store a key character, or compare a replacement character against the key.
    function void record(logic [7:0] c);
      if (!in_repl) begin
        if (key_cnt < slots - 1) begin
          key_sig[key_cnt] = c;
          key_cnt++;
        end
      end else if (repl_cnt < slots - 1) begin
        if (repl_cnt >= key_cnt || key_sig[repl_cnt] != c) mismatch = 1'b1;
        repl_cnt++;
      end
    endfunction

    // First byte after '%' or any byte inside the flags, width and precision.
    function void take_field(logic [7:0] c);
      if (is_skip(c)) begin
        phase = PH_FLAGS;
      end else if (is_mod(c)) begin
        record(c);
        phase = PH_MODS;
      end else begin
        record(c);
        phase = PH_TEXT;
      end
    endfunction

    function void parse_char(logic [7:0] c);
      case (phase)
        PH_TEXT: begin
          if (c == CH_PCT) phase = PH_PCT;
        end
        PH_PCT: begin
          if (c == CH_PCT) phase = PH_TEXT;
          else take_field(c);
        end
        PH_FLAGS: take_field(c);
        default: begin
          record(c);
          phase = is_mod(c) ? PH_MODS : PH_TEXT;
        end
      endcase
    endfunction

    function void note_input(in_item_t it);
      out_item_t rpt;
      if (it.action == ACT_KEY) begin
        // a key byte after a closed key starts a fresh key
        if (key_closed) clear();
        in_repl = 1'b0;
        if (it.text_byte == CH_NUL) begin
          key_closed = 1'b1;
          phase = PH_TEXT;
        end else begin
          parse_char(it.text_byte);
        end
      end else begin
        // the first replacement byte closes an open key and drops a pending conversion
        if (!key_closed) begin
          key_closed = 1'b1;
          phase = PH_TEXT;
        end
        in_repl = 1'b1;
        if (it.text_byte != CH_NUL) begin
          parse_char(it.text_byte);
        end else begin
          rpt.compatible   = !mismatch && repl_cnt == key_cnt;
          rpt.key_sig_len  = key_cnt[3:0];
          rpt.repl_sig_len = repl_cnt[3:0];
          expected_q.push_back(rpt);
          if (key_cnt > longest_key) longest_key = key_cnt;
          clear();
        end
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected report compatible=%0b key_sig_len=%0d repl_sig_len=%0d",
                 $time, got.compatible, got.key_sig_len, got.repl_sig_len);
        return;
      end
      want = expected_q.pop_front();
      results_seen++;
      if (want.compatible) compatible_seen++;
      if (got.compatible != want.compatible) begin
        errors++;
        $display("%0t: compatible expected %0b actual %0b",
                 $time, want.compatible, got.compatible);
      end
      if (got.key_sig_len != want.key_sig_len) begin
        errors++;
        $display("%0t: key_sig_len expected %0d actual %0d",
                 $time, want.key_sig_len, got.key_sig_len);
      end
      if (got.repl_sig_len != want.repl_sig_len) begin
        errors++;
        $display("%0t: repl_sig_len expected %0d actual %0d",
                 $time, want.repl_sig_len, got.repl_sig_len);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  sig_scoreboard sb = new(SIG_SLOTS);

  int items_sent = 0;
  int burst_left = 0;
  int stalled_in_cycles = 0;
  bit hold_req = 1'b0;

  string conv_chars = "diouxXcspfeEgGaAn";
  string mod_chars  = "hlLzjt";
  string skip_chars = "-+ #0123456789.*";

  format_signature_checker #(
    .SIG_SLOTS(SIG_SLOTS)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Sample both handshakes at the edge; note the input first so a report can
  // never race ahead of its own expectation.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_input(in_data);
      if (in_valid && in_stall) stalled_in_cycles++;
      if (out_valid && !out_stall) sb.check_result(out_data);
    end
  end

  // Receiver: switch among four random stall patterns, or hold off for a long
  // stretch when the sender asks for it.
  initial begin
    int mode;
    int cyc;
    out_stall = 1'b0;
    mode = 0;
    cyc = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
        hold_req = 1'b0;
      end else begin
        if (cyc % 50 == 0) mode = $urandom_range(0, 3);
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 2) == 0);
          2: out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= (cyc % 5 < 2);
        endcase
        cyc++;
      end
    end
  end

  // Ends a hung run.
  initial begin
    #2_000_000;
    $display("FAIL format_signature_checker");
    $finish;
  end

  // Offer one item and hold it until accepted; open a random gap at burst end.
  task automatic send_item(logic act, logic [7:0] b);
    in_item_t it;
    it.action = act;
    it.text_byte = b;
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    items_sent++;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                                : $urandom_range(1, 40);
    end else begin
      burst_left--;
    end
  endtask

  task automatic send_text(logic act, string s, bit term);
    for (int i = 0; i < s.len(); i++) send_item(act, s[i]);
    if (term) send_item(act, CH_NUL);
  endtask

  task automatic send_bytes(logic act, ref logic [7:0] q[$], input bit term);
    foreach (q[i]) send_item(act, q[i]);
    if (term) send_item(act, CH_NUL);
  endtask

  // Drop valid and wait until every queued report has been checked.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_conv();
    logic [7:0] c;
    if ($urandom_range(0, 3) != 0) return conv_chars[$urandom_range(0, conv_chars.len() - 1)];
    do c = 8'($urandom_range(1, 255));
    while (sig_scoreboard::is_skip(c) || sig_scoreboard::is_mod(c) || c == CH_PCT);
    return c;
  endfunction

  function automatic logic [7:0] pick_text();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255)); while (c == CH_PCT);
    return c;
  endfunction

  task automatic add_conversion(ref logic [7:0] sig[$], ref int lens[$]);
    int nm;
    nm = $urandom_range(0, 2);
    for (int k = 0; k < nm; k++) sig.push_back(mod_chars[$urandom_range(0, 5)]);
    sig.push_back(pick_conv());
    lens.push_back(nm + 1);
  endtask

  // Mostly short signatures, now and then long enough to hit truncation.
  task automatic build_signature(ref logic [7:0] sig[$], ref int lens[$]);
    int n;
    sig.delete();
    lens.delete();
    n = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 4) : $urandom_range(5, 12);
    for (int i = 0; i < n; i++) add_conversion(sig, lens);
  endtask

  // Spell a signature as a format string with random text, flags and widths.
  task automatic render(ref logic [7:0] sig[$], ref int lens[$], ref logic [7:0] txt[$]);
    int pos;
    pos = 0;
    txt.delete();
    foreach (lens[i]) begin
      repeat ($urandom_range(0, 3)) txt.push_back(pick_text());
      txt.push_back(CH_PCT);
      repeat ($urandom_range(0, 3)) txt.push_back(skip_chars[$urandom_range(0, 15)]);
      for (int k = 0; k < lens[i]; k++) txt.push_back(sig[pos + k]);
      pos += lens[i];
    end
    repeat ($urandom_range(0, 2)) txt.push_back(pick_text());
  endtask

  // Bend the replacement signature: change a character, drop or add a
  // conversion, or slip in an extra length modifier.
  task automatic mutate(ref logic [7:0] sig[$], ref int lens[$]);
    int pick;
    pick = $urandom_range(0, 3);
    if (lens.size() == 0) pick = 2;
    case (pick)
      0: sig[$urandom_range(0, sig.size() - 1)] = pick_conv();
      1: begin
        repeat (lens[$]) void'(sig.pop_back());
        void'(lens.pop_back());
      end
      2: add_conversion(sig, lens);
      default: begin
        sig.push_front(mod_chars[$urandom_range(0, 5)]);
        lens[0]++;
      end
    endcase
  endtask

  task automatic send_pair();
    logic [7:0] key_sig[$];
    logic [7:0] repl_sig[$];
    logic [7:0] txt[$];
    int         key_lens[$];
    int         repl_lens[$];
    build_signature(key_sig, key_lens);
    // occasionally a throwaway key first, so the real one replaces a closed key
    if ($urandom_range(0, 19) == 0) begin
      render(key_sig, key_lens, txt);
      send_bytes(ACT_KEY, txt, 1'b1);
      build_signature(key_sig, key_lens);
    end
    render(key_sig, key_lens, txt);
    // leave the key open now and then; the replacement closes it
    send_bytes(ACT_KEY, txt, $urandom_range(0, 9) != 0);
    repl_sig = key_sig;
    repl_lens = key_lens;
    if ($urandom_range(0, 1) == 0) mutate(repl_sig, repl_lens);
    render(repl_sig, repl_lens, txt);
    send_bytes(ACT_REPL, txt, 1'b1);
  endtask

  // Unstructured bytes on both strings, with terminators and stray '%'.
  task automatic send_noise();
    logic [7:0] b;
    repeat ($urandom_range(1, 12)) begin
      case ($urandom_range(0, 7))
        0: b = CH_NUL;
        1: b = CH_PCT;
        default: b = 8'($urandom_range(0, 255));
      endcase
      send_item(1'($urandom_range(0, 1)), b);
    end
  endtask

  task automatic run_directed();
    // flags and width skipped; modifier kept, conversion differs
    send_text(ACT_KEY, "%+5ld", 1'b1);
    send_text(ACT_REPL, "%lu", 1'b1);
    // escaped percent and a percent right before the terminator record nothing;
    // a percent after a width is taken as the conversion
    send_text(ACT_KEY, "%%x%", 1'b1);
    send_text(ACT_REPL, "%5%", 1'b1);
    // key left open, replacement starts with top-bit bytes and ends mid-conversion
    send_text(ACT_KEY, "%h", 1'b0);
    send_item(ACT_REPL, 8'hFF);
    send_item(ACT_REPL, 8'h80);
    send_text(ACT_REPL, "%h", 1'b1);
    // empty key twice, then an empty replacement
    send_item(ACT_KEY, CH_NUL);
    send_item(ACT_KEY, CH_NUL);
    send_item(ACT_REPL, CH_NUL);
  endtask

  initial begin
    bit hold_done;
    bit pause_done;
    hold_done = 1'b0;
    pause_done = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    run_directed();
    wait_drained();

    while (items_sent < TARGET_ITEMS) begin
      if (!hold_done && items_sent > 400) begin
        // hold the receiver off while pairs keep coming, so the block backs up
        hold_req = 1'b1;
        hold_done = 1'b1;
        repeat (6) send_pair();
      end else if (!pause_done && items_sent > 900) begin
        wait_drained();
        pause_done = 1'b1;
      end else if ($urandom_range(0, 9) == 0) begin
        send_noise();
      end else begin
        send_pair();
      end
    end

    wait_drained();
    if (sb.pending() != 0) begin
      sb.errors++;
      $display("%0t: %0d expected reports never arrived", $time, sb.pending());
    end

    $display("Sent %0d items; checked %0d reports, %0d of them compatible.",
             items_sent, sb.results_seen, sb.compatible_seen);
    $display("Longest key signature %0d; input held back for %0d cycles.",
             sb.longest_key, stalled_in_cycles);
    if (sb.errors == 0) begin
      $display("PASS format_signature_checker");
    end else begin
      $display("FAIL format_signature_checker");
    end
    $finish;
  end

endmodule
